FILE: design/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed (same cycle)");

// Consequent in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed (next cycle)");

`endif

FILE: design/rmf_pkg.sv
// Shared types and constants of the running median filter.
package rmf_pkg;

    // width of the stream payloads
    localparam int TDATA_BITS = 16;

    // control of the shared rank compare unit
    typedef struct packed {
        logic clr;
        logic en;
    } t_rank_ctl;

endpackage

FILE: design/running_median_filter_top.sv
// Running median filter: ring window plus a sequencer around one compare unit.
// Per input beat, each candidate (m = candidates tried, 1..k, k = samples held)
//   is read (READC, WAITC), ranked by one k-entry scan through the single memory
//   read port and the shared compare unit (SCAN) and tested (CHECK); a hit goes
//   to FINISH, which loads the result once the output is free. The next beat is
//   taken only after that, back in IDLE, so a stalled result holds the input.
// Reset: i_rst_n synchronous active low; empties the window (fill count, slot).
module running_median_filter_top #(
    parameter int WINDOW      = 15,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [rmf_pkg::TDATA_BITS-1:0]  i_s_tdata,  // [15:0] sample
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [rmf_pkg::TDATA_BITS-1:0]  o_m_tdata   // [15:0] median
);
    import rmf_pkg::*;

    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READC,
        ST_WAITC,
        ST_SCAN,
        ST_CHECK,
        ST_FINISH
    } t_state;

    t_state                 r_state;
    t_state                 n_state;
    logic [IDX_W-1:0]       r_wslot;
    logic [CNT_W-1:0]       r_fill;
    logic [IDX_W-1:0]       r_i;
    logic [CNT_W-1:0]       r_j;
    logic [SAMPLE_BITS-1:0] r_cand;
    logic                   r_out_valid;
    logic [TDATA_BITS-1:0]  r_out_data;

    logic                   s_beat;
    logic [SAMPLE_BITS-1:0] s_raw;
    logic [SAMPLE_BITS-1:0] s_val;
    logic [IDX_W-1:0]       rd_addr;
    logic [SAMPLE_BITS-1:0] rd_data;
    t_rank_ctl              rank_ctl;
    logic [CNT_W-1:0]       cnt_gt;
    logic [CNT_W-1:0]       cnt_ge;
    logic [CNT_W-1:0]       rank;
    logic                   hit;
    logic                   out_free;

    assign o_s_tready = (r_state == ST_IDLE);
    assign s_beat     = i_s_tvalid && o_s_tready;
    assign s_raw      = SAMPLE_BITS'(i_s_tdata);
    // zero is reserved; store it as one
    assign s_val      = (s_raw == '0) ? SAMPLE_BITS'(1) : s_raw;
    assign rank       = r_fill >> 1;
    // candidate is the answer when its rank interval covers the target rank
    assign hit        = (cnt_gt <= rank) && (rank < cnt_ge);
    assign out_free   = !r_out_valid || i_m_tready;

    always_comb begin
        rd_addr      = r_i;
        rank_ctl.clr = 1'b0;
        rank_ctl.en  = 1'b0;
        n_state      = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_beat) begin
                    n_state = ST_READC;
                end
            end
            ST_READC: begin
                rd_addr = r_i;
                n_state = ST_WAITC;
            end
            ST_WAITC: begin
                rd_addr      = '0;
                rank_ctl.clr = 1'b1;
                n_state      = ST_SCAN;
            end
            ST_SCAN: begin
                rd_addr     = r_j[IDX_W-1:0];
                rank_ctl.en = 1'b1;
                if (r_j == r_fill) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = hit ? ST_FINISH : ST_READC;
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wslot     <= '0;
            r_fill      <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // the finish state reloads the output register itself
            if (r_out_valid && i_m_tready && (r_state != ST_FINISH)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (s_beat) begin
                        r_wslot <= (r_wslot == IDX_W'(WINDOW - 1)) ? '0
                                                                   : r_wslot + IDX_W'(1);
                        if (r_fill != CNT_W'(WINDOW)) begin
                            r_fill <= r_fill + CNT_W'(1);
                        end
                        r_i <= '0;
                    end
                end
                ST_READC: begin
                end
                ST_WAITC: begin
                    r_cand <= rd_data;
                    r_j    <= CNT_W'(1);
                end
                ST_SCAN: begin
                    if (r_j != r_fill) begin
                        r_j <= r_j + CNT_W'(1);
                    end
                end
                ST_CHECK: begin
                    if (!hit) begin
                        r_i <= r_i + IDX_W'(1);
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= TDATA_BITS'(r_cand);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    rmf_window_mem #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .IDX_W       (IDX_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (s_beat),
        .i_waddr (r_wslot),
        .i_wdata (s_val),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    rmf_rank_unit #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .CNT_W       (CNT_W)
    ) u_rank (
        .i_clk  (i_clk),
        .i_ctl  (rank_ctl),
        .i_cand (r_cand),
        .i_val  (rd_data),
        .o_gt   (cnt_gt),
        .o_ge   (cnt_ge)
    );

endmodule

FILE: design/rmf_window_mem.sv
// Sample window ring storage: one write port, one registered read port.
module rmf_window_mem #(
    parameter int WINDOW      = 15,
    parameter int SAMPLE_BITS = 16,
    parameter int IDX_W       = 4
) (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [IDX_W-1:0]       i_waddr,
    input  logic [SAMPLE_BITS-1:0] i_wdata,
    input  logic [IDX_W-1:0]       i_raddr,
    output logic [SAMPLE_BITS-1:0] o_rdata
);

    logic [SAMPLE_BITS-1:0] r_mem [WINDOW];
    logic [SAMPLE_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/rmf_rank_unit.sv
// Shared compare unit: counts window entries above / at-or-above a candidate.
module rmf_rank_unit #(
    parameter int SAMPLE_BITS = 16,
    parameter int CNT_W       = 4
) (
    input  logic                   i_clk,
    input  rmf_pkg::t_rank_ctl     i_ctl,
    input  logic [SAMPLE_BITS-1:0] i_cand,
    input  logic [SAMPLE_BITS-1:0] i_val,
    output logic [CNT_W-1:0]       o_gt,
    output logic [CNT_W-1:0]       o_ge
);
    import rmf_pkg::*;

    logic [CNT_W-1:0] r_gt;
    logic [CNT_W-1:0] r_ge;

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_gt <= '0;
            r_ge <= '0;
        end else if (i_ctl.en) begin
            if (i_val > i_cand) begin
                r_gt <= r_gt + CNT_W'(1);
            end
            if (i_val >= i_cand) begin
                r_ge <= r_ge + CNT_W'(1);
            end
        end
    end

    assign o_gt = r_gt;
    assign o_ge = r_ge;

endmodule

FILE: design/rmf_checker.sv
// Port-level checker for the running median filter, bound to the top level.
`include "assert_macros.svh"

module rmf_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_tvalid,
    input logic                           o_s_tready,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [rmf_pkg::TDATA_BITS-1:0] o_m_tdata
);
    import rmf_pkg::*;

    logic in_beat;

    assign in_beat = i_s_tvalid && o_s_tready;

    // a stalled result beat holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready,
                 o_m_tvalid && $stable(o_m_tdata))
    // busy right after taking a sample
    `ASSERT_NEXT(a_busy_after_in, i_clk, i_rst_n, in_beat, !o_s_tready)
    // no result can appear the cycle after a sample is taken
    `ASSERT_NEXT(a_no_instant_out, i_clk, i_rst_n, in_beat, !$rose(o_m_tvalid))
    // a new result is only produced while the input side is closed
    `ASSERT_SAME(a_out_while_busy, i_clk, i_rst_n, $rose(o_m_tvalid), !$past(o_s_tready))

endmodule

bind running_median_filter_top rmf_checker u_rmf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
